### src/aes128_block_decrypt_assert.svh
// assertion macros used by the top rtl file
`ifndef AES128_BLOCK_DECRYPT_ASSERT_SVH
`define AES128_BLOCK_DECRYPT_ASSERT_SVH

// same-cycle implication
`define ABD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aes128 decrypt check failed");

// next-cycle implication
`define ABD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aes128 decrypt check failed");

`endif

### src/aes128bd_pkg.sv
`timescale 1ns / 1ps
package aes128bd_pkg;

  localparam int unsigned NR = 10;

  typedef logic [127:0] blk_t;
  typedef logic [NR:0][127:0] rk_array_t;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // round constant for expansion step n (1..10)
  function automatic logic [7:0] rcon(input logic [3:0] n);
    logic [7:0] r;
    case (n)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of a block, byte 0 most significant
  function automatic logic [7:0] get_byte(input blk_t s, input int unsigned k);
    return s[127 - 8*k -: 8];
  endfunction

  // next round key from the previous one
  function automatic blk_t next_round_key(input blk_t prev, input logic [3:0] n);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = prev[127:96];
    w1 = prev[95:64];
    w2 = prev[63:32];
    w3 = prev[31:0];
    t = {SBOX[w3[23:16]] ^ rcon(n), SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic blk_t inv_shift_sub(input blk_t s);
    blk_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(((c + r) % 4)*4 + r) -: 8] = INV_SBOX[get_byte(s, c*4 + r)];
      end
    end
    return t;
  endfunction

  function automatic blk_t inv_mix(input blk_t s);
    blk_t o;
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] e9 [4];
    logic [7:0] eb [4];
    logic [7:0] ed [4];
    logic [7:0] ee [4];
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]  = get_byte(s, c*4 + r);
        m2[r] = xtime(a[r]);
        m4[r] = xtime(m2[r]);
        m8[r] = xtime(m4[r]);
        e9[r] = m8[r] ^ a[r];
        eb[r] = m8[r] ^ m2[r] ^ a[r];
        ed[r] = m8[r] ^ m4[r] ^ a[r];
        ee[r] = m8[r] ^ m4[r] ^ m2[r];
      end
      o[127 - 8*(c*4)     -: 8] = ee[0] ^ eb[1] ^ ed[2] ^ e9[3];
      o[127 - 8*(c*4 + 1) -: 8] = e9[0] ^ ee[1] ^ eb[2] ^ ed[3];
      o[127 - 8*(c*4 + 2) -: 8] = ed[0] ^ e9[1] ^ ee[2] ^ eb[3];
      o[127 - 8*(c*4 + 3) -: 8] = eb[0] ^ ed[1] ^ e9[2] ^ ee[3];
    end
    return o;
  endfunction

endpackage

### src/aes128bd_kexp.sv
`timescale 1ns / 1ps
module aes128bd_kexp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [63:0]             cfg_data,
  output logic                    busy,
  output aes128bd_pkg::rk_array_t round_keys
);

  logic [63:0]                  key_high;
  logic [63:0]                  key_low;
  logic [3:0]                   cnt;
  aes128bd_pkg::blk_t           cur;
  aes128bd_pkg::blk_t           prev;
  aes128bd_pkg::blk_t           rk_next;
  logic [aes128bd_pkg::NR:1][127:0] rks;

  assign busy      = (cnt != 4'd0);
  assign cfg_ready = !busy;
  assign prev      = (cnt == 4'd1) ? {key_high, key_low} : cur;
  assign rk_next   = aes128bd_pkg::next_round_key(prev, cnt);

  always_comb begin
    round_keys[0] = {key_high, key_low};
    for (int i = 1; i <= aes128bd_pkg::NR; i++) begin
      round_keys[i] = rks[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      cnt      <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aes128bd_pkg::REG_KEY_HIGH: begin
          key_high <= cfg_data;
          cnt      <= 4'd1;
        end
        aes128bd_pkg::REG_KEY_LOW: begin
          key_low <= cfg_data;
          cnt     <= 4'd1;
        end
        default: begin
        end
      endcase
    end else if (busy) begin
      cnt <= (cnt == 4'(aes128bd_pkg::NR)) ? 4'd0 : cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rks[cnt] <= rk_next;
      cur      <= rk_next;
    end
  end

endmodule

### src/aes128bd_round.sv
`timescale 1ns / 1ps
module aes128bd_round (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  aes128bd_pkg::blk_t in_state,
  input  aes128bd_pkg::blk_t rkey,
  output logic               out_vld,
  output aes128bd_pkg::blk_t out_state
);

  // inverse shift rows, inverse sbox, key add, inverse mix columns
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_state <= aes128bd_pkg::inv_mix(aes128bd_pkg::inv_shift_sub(in_state) ^ rkey);
  end

endmodule

### src/aes128_block_decrypt.sv
`timescale 1ns / 1ps
// aes-128 inverse cipher, one request accepted per cycle while busy is low, fully pipelined
// pipeline: the input key add loads at the accepting edge, then one register per round
// after it; the result strobe (done) rises with the last round register
// throughput: one block per cycle while busy is low, done cannot be held off by the receiver
// reset: key clears to zero and the key schedule is rebuilt; busy is high after
// reset and after every key write while round keys expand
`include "aes128_block_decrypt_assert.svh"
module aes128_block_decrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] cipher_high,
  input  logic [63:0] cipher_low,
  output logic        done,
  output logic [63:0] plain_high,
  output logic [63:0] plain_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int unsigned NR = aes128bd_pkg::NR;

  aes128bd_pkg::rk_array_t round_keys;
  logic                    accept;

  // stage k holds the state after round (NR - k); stage 0 is after the first key add
  logic                    vld [NR];
  aes128bd_pkg::blk_t      st  [NR];

  // key schedule sequencer, one round key per cycle
  aes128bd_kexp u_kexp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .busy       (busy),
    .round_keys (round_keys)
  );

  assign accept = start && !busy;

  // input stage: add last round key
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    st[0] <= {cipher_high, cipher_low} ^ round_keys[NR];
  end

  // nine full inverse rounds, each its own register stage
  for (genvar k = 1; k < NR; k++) begin : g_round
    aes128bd_round u_round (
      .clk       (clk),
      .rst       (rst),
      .in_vld    (vld[k-1]),
      .in_state  (st[k-1]),
      .rkey      (round_keys[NR - k]),
      .out_vld   (vld[k]),
      .out_state (st[k])
    );
  end

  // final round: no inverse mix columns, key 0
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[NR-1];
    end
  end

  always_ff @(posedge clk) begin
    {plain_high, plain_low} <= aes128bd_pkg::inv_shift_sub(st[NR-1]) ^ round_keys[0];
  end

  // an accepted request shows up in the first stage
  `ABD_ASSERT_NEXT(a_accept_enters, clk, rst, accept, vld[0])
  // last round stage always produces a strobe next cycle
  `ABD_ASSERT_NEXT(a_last_to_done, clk, rst, vld[NR-1], done)
  // no strobe without an item in the last stage
  `ABD_ASSERT_NEXT(a_no_spurious_done, clk, rst, !vld[NR-1], !done)
  // config port closed while round keys expand
  `ABD_ASSERT_NOW(a_cfg_closed, clk, rst, busy, !cfg_ready)

endmodule

### verif/aes128_block_decrypt_tb.sv
`timescale 1ns / 1ps
// aes-128 inverse cipher: known answers plus random blocks under changing keys
module aes128_block_decrypt_tb;

  // out-of-range register indexes, writes to them must be ignored
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  // extra wait after the last expected result strobe has arrived
  localparam int DRAIN_PAD = 16;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } plain_t;

  // one directed row: either a register write or a block request
  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [63:0] a;
    logic [63:0] b;
    bit          known;
    logic [63:0] eh;
    logic [63:0] el;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] cipher_high = '0;
  logic [63:0] cipher_low = '0;
  logic        done;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes128_block_decrypt u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cipher_high(cipher_high), .cipher_low(cipher_low),
    .done(done), .plain_high(plain_high), .plain_low(plain_low),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state: shadow key and s-box tables built from field math
  logic [63:0] key_hi_shadow = '0;
  logic [63:0] key_lo_shadow = '0;
  logic [7:0]  sbox_fwd [256];
  logic [7:0]  sbox_inv [256];
  plain_t      plain_due [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          idle_pct = 0;

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xt(a);
    end
    return p;
  endfunction

  // x^254, zero maps to zero
  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 0; i < 254; i++) r = gmul(r, x);
    return x == 8'h00 ? 8'h00 : r;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  // state byte k sits at bits 127-8k, column k/4, row k%4
  function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(((c + r) % 4)*4 + r) -: 8] = sbox_inv[s[127 - 8*(c*4 + r) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] unmix_columns(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      o[127 - 32*c -: 8] = gmul(8'h0e, a0) ^ gmul(8'h0b, a1) ^ gmul(8'h0d, a2) ^ gmul(8'h09, a3);
      o[119 - 32*c -: 8] = gmul(8'h09, a0) ^ gmul(8'h0e, a1) ^ gmul(8'h0b, a2) ^ gmul(8'h0d, a3);
      o[111 - 32*c -: 8] = gmul(8'h0d, a0) ^ gmul(8'h09, a1) ^ gmul(8'h0e, a2) ^ gmul(8'h0b, a3);
      o[103 - 32*c -: 8] = gmul(8'h0b, a0) ^ gmul(8'h0d, a1) ^ gmul(8'h09, a2) ^ gmul(8'h0e, a3);
    end
    return o;
  endfunction

  function automatic plain_t decrypt_block(input logic [127:0] key, input logic [127:0] blk);
    logic [31:0]  w [44];
    logic [31:0]  tw;
    logic [7:0]   rc;
    logic [127:0] st;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127 - 32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      tw = w[i-1];
      if (i % 4 == 0) begin
        tw = {tw[23:0], tw[31:24]};
        tw = {sbox_fwd[tw[31:24]] ^ rc, sbox_fwd[tw[23:16]],
              sbox_fwd[tw[15:8]], sbox_fwd[tw[7:0]]};
        rc = xt(rc);
      end
      w[i] = w[i-4] ^ tw;
    end
    st = blk ^ {w[40], w[41], w[42], w[43]};
    for (int rnd = 9; rnd > 0; rnd--) begin
      st = unshift_unsub(st) ^ {w[4*rnd], w[4*rnd+1], w[4*rnd+2], w[4*rnd+3]};
      st = unmix_columns(st);
    end
    st = unshift_unsub(st) ^ {w[0], w[1], w[2], w[3]};
    return st;
  endfunction

  // global watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result checker: done is a one-cycle strobe, compare with oldest expectation
  always @(posedge clk) begin
    plain_t exp_p;
    if (!rst && done) begin
      if (plain_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h %h", plain_high, plain_low);
      end else begin
        exp_p = plain_due.pop_front();
        if (plain_high !== exp_p.hi || plain_low !== exp_p.lo) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h got %h %h", exp_p.hi, exp_p.lo,
                     plain_high, plain_low);
        end
      end
    end
  end

  // wait out the pipeline so the block is idle before a key change
  task automatic drain_pipe();
    start <= 1'b0;
    while (plain_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    if (idx == aes128bd_pkg::REG_KEY_HIGH) key_hi_shadow = val;
    else if (idx == aes128bd_pkg::REG_KEY_LOW) key_lo_shadow = val;
  endtask

  // one block request; a known answer row also checks the predictor itself
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input bit known, input logic [63:0] eh, input logic [63:0] el);
    plain_t p;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    cipher_high <= hi;
    cipher_low  <= lo;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    p = decrypt_block({key_hi_shadow, key_lo_shadow}, {hi, lo});
    if (known) begin
      if (p.hi !== eh || p.lo !== el) begin
        mismatches++;
        if (mismatches <= 10) $display("known answer off %h %h", p.hi, p.lo);
      end
      p.hi = eh;
      p.lo = el;
    end
    plain_due.push_back(p);
    // start stays high; next call either reloads it or lowers it
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  row_t directed [] = '{
    // reset key is zero: the zero-key encryption of a zero block
    '{0, 2'd0, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, 64'h0, 64'h0},
    '{0, 2'd0, 64'h0, 64'h0, 0, 64'h0, 64'h0},
    '{0, 2'd0, '1, '1, 0, 64'h0, 64'h0},
    // standard test key 000102..0f
    '{1, aes128bd_pkg::REG_KEY_HIGH, 64'h0001020304050607, 64'h0, 0, 64'h0, 64'h0},
    '{1, aes128bd_pkg::REG_KEY_LOW,  64'h08090a0b0c0d0e0f, 64'h0, 0, 64'h0, 64'h0},
    '{0, 2'd0, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
      64'h0011223344556677, 64'h8899aabbccddeeff},
    '{0, 2'd0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0, 64'h0, 64'h0},
    // spare indexes must leave the key alone
    '{1, REG_SPARE_A, '1, 64'h0, 0, 64'h0, 64'h0},
    '{1, REG_SPARE_B, '1, 64'h0, 0, 64'h0, 64'h0},
    '{0, 2'd0, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
      64'h0011223344556677, 64'h8899aabbccddeeff},
    // all-ones key
    '{1, aes128bd_pkg::REG_KEY_HIGH, '1, 64'h0, 0, 64'h0, 64'h0},
    '{1, aes128bd_pkg::REG_KEY_LOW,  '1, 64'h0, 0, 64'h0, 64'h0},
    '{0, 2'd0, 64'h0, 64'h0, 0, 64'h0, 64'h0},
    '{0, 2'd0, '1, '1, 0, 64'h0, 64'h0},
    '{0, 2'd0, 64'h8000000000000000, 64'h1, 0, 64'h0, 64'h0},
    // only the low half changes
    '{1, aes128bd_pkg::REG_KEY_LOW,  64'h0, 64'h0, 0, 64'h0, 64'h0},
    '{0, 2'd0, 64'h0123456789abcdef, 64'hfedcba9876543210, 0, 64'h0, 64'h0}
  };

  initial begin
    logic [1:0] ridx;
    for (int i = 0; i < 256; i++) sbox_fwd[i] = 8'h00;
    for (int i = 0; i < 256; i++) begin
      logic [7:0] b;
      b = ginv(i[7:0]);
      sbox_fwd[i] = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
    end
    for (int i = 0; i < 256; i++) sbox_inv[sbox_fwd[i]] = i[7:0];

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table, back to back
    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].idx, directed[i].a);
      else send_block(directed[i].a, directed[i].b, directed[i].known,
                      directed[i].eh, directed[i].el);
    end

    // random part: three idle regimes, each with several keys
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 29 : (ph == 1) ? 86 : 0;
      for (int k = 0; k < 5; k++) begin
        case ($urandom_range(4))
          0: begin
            write_reg(aes128bd_pkg::REG_KEY_HIGH, '0);
            write_reg(aes128bd_pkg::REG_KEY_LOW, '1);
          end
          1: write_reg(aes128bd_pkg::REG_KEY_HIGH, rnd64());
          2: begin
            ridx = $urandom_range(1) ? REG_SPARE_A : REG_SPARE_B;
            write_reg(ridx, rnd64());
            write_reg(aes128bd_pkg::REG_KEY_LOW, rnd64());
          end
          default: begin
            write_reg(aes128bd_pkg::REG_KEY_HIGH, rnd64());
            write_reg(aes128bd_pkg::REG_KEY_LOW, rnd64());
          end
        endcase
        for (int n = 0; n < 125; n++) begin
          // mostly random content, now and then an extreme block
          case ($urandom_range(15))
            0:       send_block('0, '0, 0, '0, '0);
            1:       send_block('1, '1, 0, '0, '0);
            default: send_block(rnd64(), rnd64(), 0, '0, '0);
          endcase
        end
      end
    end

    // wait for the last results, then a little longer for stray strobes
    drain_pipe();
    if (mismatches == 0 && plain_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/aes128bd_pkg.sv
src/aes128bd_kexp.sv
src/aes128bd_round.sv
src/aes128_block_decrypt.sv
verif/aes128_block_decrypt_tb.sv
